// ===== src/spp_pkg.sv =====
package spp_pkg;

  localparam int COORD_W   = 16;
  localparam int OUT_IDX_W = 3;

  typedef struct packed {
    logic                      en;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
  } spp_body_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SPREAD,
    ST_AXIS,
    ST_SORT_RI,
    ST_SORT_KI,
    ST_SORT_RJ,
    ST_SORT_CJ,
    ST_SORT_WR,
    ST_SW_RO,
    ST_SW_RB,
    ST_SW_LB,
    ST_SW_RA,
    ST_SW_RM,
    ST_SW_CM,
    ST_SW_EMIT,
    ST_SW_APP,
    ST_FIN
  } spp_state_t;

  typedef struct packed {
    logic in_ready;
    logic spr_step;
    logic axis_latch;
    logic sort_rd_i;
    logic sort_key;
    logic sort_rd_j;
    logic sort_cmp;
    logic sort_wr;
    logic sw_rd_order;
    logic sw_rd_body;
    logic sw_load_body;
    logic sw_skip;
    logic sw_rd_act;
    logic sw_rd_amax;
    logic sw_drop;
    logic sw_emit;
    logic sw_append;
    logic finish;
  } spp_cmd_t;

  typedef struct packed {
    logic in_accept;
    logic in_final;
    logic spr_done;
    logic i_last;
    logic j_last_sort;
    logic p_last;
    logic b_enabled;
    logic act_empty;
    logic j_last_act;
    logic overlap;
    logic emit_ok;
    logic out_free;
  } spp_status_t;

endpackage

// ===== src/spp_in_if.sv =====
interface spp_in_if;
  import spp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] box_min_x;
  logic signed [COORD_W-1:0] box_min_y;
  logic signed [COORD_W-1:0] box_max_x;
  logic signed [COORD_W-1:0] box_max_y;
  logic signed [COORD_W-1:0] centre_x;
  logic signed [COORD_W-1:0] centre_y;
  logic                      body_enabled;
  logic                      final_body;

  modport source (
    output valid, box_min_x, box_min_y, box_max_x, box_max_y, centre_x, centre_y,
           body_enabled, final_body,
    input  ready
  );

  modport sink (
    input  valid, box_min_x, box_min_y, box_max_x, box_max_y, centre_x, centre_y,
           body_enabled, final_body,
    output ready
  );

endinterface

// ===== src/spp_out_if.sv =====
interface spp_out_if;
  import spp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 pair_valid;
  logic [OUT_IDX_W-1:0] newer_body;
  logic [OUT_IDX_W-1:0] older_body;
  logic                 last_pair;
  logic                 axis_is_y;
  logic                 dropped_bodies;

  modport source (
    output valid, pair_valid, newer_body, older_body, last_pair, axis_is_y,
           dropped_bodies,
    input  ready
  );

  modport sink (
    input  valid, pair_valid, newer_body, older_body, last_pair, axis_is_y,
           dropped_bodies,
    output ready
  );

endinterface

// ===== src/spp_ctrl.sv =====
module spp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  spp_pkg::spp_status_t status,
  output spp_pkg::spp_cmd_t    cmd
);
  import spp_pkg::*;

  spp_state_t state;
  spp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (status.in_accept && status.in_final) state_next = ST_SPREAD;
      end
      ST_SPREAD: begin
        if (status.spr_done) state_next = ST_AXIS;
      end
      ST_AXIS:    state_next = ST_SORT_RI;
      ST_SORT_RI: state_next = ST_SORT_KI;
      ST_SORT_KI: state_next = ST_SORT_RJ;
      ST_SORT_RJ: state_next = ST_SORT_CJ;
      ST_SORT_CJ: begin
        state_next = status.j_last_sort ? ST_SORT_WR : ST_SORT_RJ;
      end
      ST_SORT_WR: begin
        state_next = status.i_last ? ST_SW_RO : ST_SORT_RI;
      end
      ST_SW_RO: state_next = ST_SW_RB;
      ST_SW_RB: state_next = ST_SW_LB;
      ST_SW_LB: begin
        if (status.b_enabled) begin
          state_next = status.act_empty ? ST_SW_APP : ST_SW_RA;
        end else begin
          state_next = status.p_last ? ST_FIN : ST_SW_RO;
        end
      end
      ST_SW_RA: state_next = ST_SW_RM;
      ST_SW_RM: state_next = ST_SW_CM;
      ST_SW_CM: begin
        if (status.overlap) begin
          state_next = ST_SW_EMIT;
        end else begin
          state_next = status.j_last_act ? ST_SW_APP : ST_SW_RA;
        end
      end
      ST_SW_EMIT: begin
        if (status.emit_ok) state_next = status.j_last_act ? ST_SW_APP : ST_SW_RA;
      end
      ST_SW_APP: begin
        state_next = status.p_last ? ST_FIN : ST_SW_RO;
      end
      ST_FIN: begin
        if (status.out_free) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_LOAD:    cmd.in_ready    = 1'b1;
      ST_SPREAD:  cmd.spr_step    = 1'b1;
      ST_AXIS:    cmd.axis_latch  = 1'b1;
      ST_SORT_RI: cmd.sort_rd_i   = 1'b1;
      ST_SORT_KI: cmd.sort_key    = 1'b1;
      ST_SORT_RJ: cmd.sort_rd_j   = 1'b1;
      ST_SORT_CJ: cmd.sort_cmp    = 1'b1;
      ST_SORT_WR: cmd.sort_wr     = 1'b1;
      ST_SW_RO:   cmd.sw_rd_order = 1'b1;
      ST_SW_RB:   cmd.sw_rd_body  = 1'b1;
      ST_SW_LB: begin
        cmd.sw_load_body = status.b_enabled;
        cmd.sw_skip      = !status.b_enabled;
      end
      ST_SW_RA:   cmd.sw_rd_act   = 1'b1;
      ST_SW_RM:   cmd.sw_rd_amax  = 1'b1;
      ST_SW_CM:   cmd.sw_drop     = !status.overlap;
      ST_SW_EMIT: cmd.sw_emit     = status.emit_ok;
      ST_SW_APP:  cmd.sw_append   = 1'b1;
      ST_FIN:     cmd.finish      = status.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

// ===== src/spp_dp.sv =====
module spp_dp #(
  parameter int MAX_BODIES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  spp_pkg::spp_cmd_t  cmd,
  output spp_pkg::spp_status_t status,
  spp_in_if.sink            items_in,
  spp_out_if.source         pairs_out
);
  import spp_pkg::*;

  localparam int IDX_W = $clog2(MAX_BODIES);
  localparam int CNT_W = $clog2(MAX_BODIES + 1);
  localparam int SUM_W = COORD_W + IDX_W + 1;
  localparam int SQ_W  = 2 * COORD_W + IDX_W;
  localparam int SPR_W = 2 * SUM_W + 2;
  localparam int K_W   = $clog2(SUM_W);

  spp_body_t        body_mem [MAX_BODIES];
  logic [IDX_W-1:0] order_mem [MAX_BODIES];
  logic [IDX_W-1:0] act_mem [MAX_BODIES];

  spp_body_t        body_q;
  logic [IDX_W-1:0] order_q;
  logic [IDX_W-1:0] act_q;
  logic [IDX_W-1:0] body_rd_addr;
  logic             act_we;
  logic [IDX_W-1:0] act_wr_addr;
  logic [IDX_W-1:0] act_wr_data;

  logic [CNT_W-1:0]        body_count;
  logic                    overflow_seen;
  logic signed [SUM_W-1:0] sum_pos_x;
  logic signed [SUM_W-1:0] sum_pos_y;
  logic [SQ_W-1:0]         sum_sq_x;
  logic [SQ_W-1:0]         sum_sq_y;
  logic signed [SPR_W-1:0] spread_x;
  logic signed [SPR_W-1:0] spread_y;
  logic [K_W-1:0]          k;
  logic                    axis_y;

  logic [IDX_W-1:0]          i;
  logic [IDX_W-1:0]          j;
  logic [IDX_W-1:0]          p;
  logic [IDX_W-1:0]          rank;
  logic signed [COORD_W-1:0] key_i;
  logic [CNT_W-1:0]          w;
  logic [CNT_W-1:0]          act_count;
  logic [IDX_W-1:0]          bidx;
  logic [IDX_W-1:0]          aidx;
  logic signed [COORD_W-1:0] bmin;
  logic                      held_valid;
  logic [IDX_W-1:0]          held_new;
  logic [IDX_W-1:0]          held_old;

  logic                        in_accept;
  logic                        store_ok;
  logic signed [COORD_W-1:0]   key_q;
  logic signed [COORD_W-1:0]   amax_q;
  logic signed [2*COORD_W-1:0] sq_cx;
  logic signed [2*COORD_W-1:0] sq_cy;
  logic [SUM_W-1:0]            abs_x;
  logic [SUM_W-1:0]            abs_y;
  logic [SUM_W-1:0]            n_ext;
  logic [SPR_W-1:0]            tp_x;
  logic [SPR_W-1:0]            tp_y;
  logic [SPR_W-1:0]            tm_x;
  logic [SPR_W-1:0]            tm_y;
  logic                        out_free;
  logic                        push;

  assign items_in.ready = cmd.in_ready;
  assign in_accept      = items_in.valid && cmd.in_ready;
  assign store_ok       = body_count < CNT_W'(MAX_BODIES);

  assign key_q  = axis_y ? body_q.min_y : body_q.min_x;
  assign amax_q = axis_y ? body_q.max_y : body_q.max_x;

  assign sq_cx = items_in.centre_x * items_in.centre_x;
  assign sq_cy = items_in.centre_y * items_in.centre_y;

  assign abs_x = sum_pos_x[SUM_W-1] ? SUM_W'(-sum_pos_x) : SUM_W'(sum_pos_x);
  assign abs_y = sum_pos_y[SUM_W-1] ? SUM_W'(-sum_pos_y) : SUM_W'(sum_pos_y);
  assign n_ext = SUM_W'(body_count);
  assign tp_x  = n_ext[k] ? (SPR_W'(sum_sq_x) << k) : '0;
  assign tp_y  = n_ext[k] ? (SPR_W'(sum_sq_y) << k) : '0;
  assign tm_x  = abs_x[k] ? (SPR_W'(abs_x) << k) : '0;
  assign tm_y  = abs_y[k] ? (SPR_W'(abs_y) << k) : '0;

  assign out_free = !pairs_out.valid || pairs_out.ready;
  assign push     = (cmd.sw_emit && held_valid) || cmd.finish;

  always_comb begin
    priority if (cmd.sort_rd_i) begin
      body_rd_addr = i;
    end else if (cmd.sort_rd_j) begin
      body_rd_addr = j;
    end else if (cmd.sw_rd_body) begin
      body_rd_addr = order_q;
    end else begin
      body_rd_addr = act_q;
    end
  end

  always_comb begin
    act_we      = cmd.sw_emit || cmd.sw_append;
    act_wr_addr = w[IDX_W-1:0];
    act_wr_data = cmd.sw_emit ? aidx : bidx;
  end

  always_ff @(posedge clk) begin
    if (in_accept && store_ok) begin
      body_mem[body_count[IDX_W-1:0]] <= '{
        en:    items_in.body_enabled,
        min_x: items_in.box_min_x,
        min_y: items_in.box_min_y,
        max_x: items_in.box_max_x,
        max_y: items_in.box_max_y
      };
    end
    body_q <= body_mem[body_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_wr) begin
      order_mem[rank] <= i;
    end
    if (cmd.sw_rd_order) begin
      order_q <= order_mem[p];
    end
  end

  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[act_wr_addr] <= act_wr_data;
    end
    if (cmd.sw_rd_act) begin
      act_q <= act_mem[j];
    end
  end

  // set accumulation and bit-serial spread
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      body_count    <= '0;
      overflow_seen <= 1'b0;
      sum_pos_x     <= '0;
      sum_pos_y     <= '0;
      sum_sq_x      <= '0;
      sum_sq_y      <= '0;
    end else if (in_accept) begin
      if (store_ok) begin
        body_count <= body_count + CNT_W'(1);
        sum_pos_x  <= sum_pos_x + SUM_W'(items_in.centre_x);
        sum_pos_y  <= sum_pos_y + SUM_W'(items_in.centre_y);
        sum_sq_x   <= sum_sq_x + SQ_W'($unsigned(sq_cx));
        sum_sq_y   <= sum_sq_y + SQ_W'($unsigned(sq_cy));
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && items_in.final_body) begin
      spread_x <= '0;
      spread_y <= '0;
      k        <= '0;
    end else if (cmd.spr_step) begin
      spread_x <= spread_x + $signed(tp_x) - $signed(tm_x);
      spread_y <= spread_y + $signed(tp_y) - $signed(tm_y);
      k        <= k + K_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.axis_latch) begin
      axis_y <= spread_x < spread_y;
    end
  end

  // rank sort and sweep counters
  always_ff @(posedge clk) begin
    if (cmd.axis_latch) begin
      i         <= '0;
      p         <= '0;
      act_count <= '0;
    end
    if (cmd.sort_key) begin
      key_i <= key_q;
      j     <= '0;
      rank  <= '0;
    end
    if (cmd.sort_cmp) begin
      if ((key_q < key_i) || ((key_q == key_i) && (j < i))) begin
        rank <= rank + IDX_W'(1);
      end
      j <= j + IDX_W'(1);
    end
    if (cmd.sort_wr) begin
      i <= i + IDX_W'(1);
    end
    if (cmd.sw_rd_body) begin
      bidx <= order_q;
    end
    if (cmd.sw_load_body) begin
      bmin <= key_q;
      j    <= '0;
      w    <= '0;
    end
    if (cmd.sw_skip) begin
      p <= p + IDX_W'(1);
    end
    if (cmd.sw_rd_amax) begin
      aidx <= act_q;
    end
    if (cmd.sw_drop) begin
      j <= j + IDX_W'(1);
    end
    if (cmd.sw_emit) begin
      j <= j + IDX_W'(1);
      w <= w + CNT_W'(1);
    end
    if (cmd.sw_append) begin
      act_count <= w + CNT_W'(1);
      p         <= p + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      held_valid <= 1'b0;
    end else if (cmd.sw_emit) begin
      held_valid <= 1'b1;
    end
    if (cmd.sw_emit) begin
      held_new <= bidx;
      held_old <= aidx;
    end
  end

  // output register, one pair held back to mark the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      pairs_out.valid <= 1'b0;
    end else if (push) begin
      pairs_out.valid <= 1'b1;
    end else if (pairs_out.ready) begin
      pairs_out.valid <= 1'b0;
    end
    if (push) begin
      pairs_out.pair_valid     <= held_valid;
      pairs_out.newer_body     <= held_valid ? OUT_IDX_W'(held_new) : '0;
      pairs_out.older_body     <= held_valid ? OUT_IDX_W'(held_old) : '0;
      pairs_out.last_pair      <= cmd.finish;
      pairs_out.axis_is_y      <= axis_y;
      pairs_out.dropped_bodies <= overflow_seen;
    end
  end

  assign status.in_accept   = in_accept;
  assign status.in_final    = items_in.final_body;
  assign status.spr_done    = k == K_W'(SUM_W - 1);
  assign status.i_last      = CNT_W'(i) == body_count - CNT_W'(1);
  assign status.j_last_sort = CNT_W'(j) == body_count - CNT_W'(1);
  assign status.p_last      = CNT_W'(p) == body_count - CNT_W'(1);
  assign status.b_enabled   = body_q.en;
  assign status.act_empty   = act_count == '0;
  assign status.j_last_act  = CNT_W'(j) == act_count - CNT_W'(1);
  assign status.overlap     = !(bmin > amax_q);
  assign status.emit_ok     = !held_valid || out_free;
  assign status.out_free    = out_free;

endmodule

// ===== src/sweep_and_prune_pair_finder_top.sv =====
// Sweep-and-prune pair finder. Bodies load one per cycle while the input is ready, numbered
// by load order; a body beyond MAX_BODIES is discarded and flagged on every result of the
// set. The body marked final_body closes the set: the spread of the centres picks the axis
// (a bit-serial multiply), then a rank sort over the single-port body memory orders the bodies.
// The sweep takes the bodies in rank order; an enabled one drops each active-list entry it
// no longer overlaps, pairs with each one it does overlap, and is then appended. The last
// result is flushed at the end, and output stalls hold the sweep. Each pair is
// one result, the last one flagged; a set with no pairs returns one empty result.
// New bodies are taken again once the last result is in the output register.
module sweep_and_prune_pair_finder_top #(
  parameter int MAX_BODIES = 8
) (
  input logic       clk,
  input logic       rst,
  spp_in_if.sink    items_in,
  spp_out_if.source pairs_out
);
  import spp_pkg::*;

  spp_cmd_t    cmd;
  spp_status_t status;

  spp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  spp_dp #(
    .MAX_BODIES (MAX_BODIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .items_in  (items_in),
    .pairs_out (pairs_out)
  );

  a_final_stops_load: assert property (@(posedge clk) disable iff (rst)
    (items_in.valid && items_in.ready && items_in.final_body) |=> !items_in.ready)
    else $error("input taken while a set is being swept");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (pairs_out.valid && !pairs_out.pair_valid) |-> pairs_out.last_pair)
    else $error("empty result not marked last");

  a_pair_distinct: assert property (@(posedge clk) disable iff (rst)
    (pairs_out.valid && pairs_out.pair_valid) |-> (pairs_out.newer_body != pairs_out.older_body))
    else $error("pair of a body with itself");

endmodule

// ===== dv/sweep_and_prune_pair_finder_checker.sv =====
module sweep_and_prune_pair_finder_checker (
  input logic    clk,
  input logic    rst,
  spp_in_if      items_in,
  spp_out_if     pairs_out,
  output int     fail_count,
  output int     pending_pairs,
  output int     sets_closed,
  output int     pairs_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import spp_pkg::*;

  localparam int MAX_BODIES = 8;

  typedef struct packed {
    logic                 pair_valid;
    logic [OUT_IDX_W-1:0] newer_body;
    logic [OUT_IDX_W-1:0] older_body;
    logic                 last_pair;
    logic                 axis_is_y;
    logic                 dropped_bodies;
  } pair_rec_t;

  spp_body_t bodies [MAX_BODIES];
  int         n_bodies;
  bit         overflow;
  longint     sum_x, sum_y, sq_x, sq_y;
  pair_rec_t  expected_pairs [$];

  assign pending_pairs = expected_pairs.size();

  function automatic longint axis_min(spp_body_t b, bit ya);
    return ya ? longint'(b.min_y) : longint'(b.min_x);
  endfunction

  function automatic longint axis_max(spp_body_t b, bit ya);
    return ya ? longint'(b.max_y) : longint'(b.max_x);
  endfunction

  task automatic sweep_set();
    longint    spread_x, spread_y;
    bit        ya;
    int        order [MAX_BODIES];
    int        active [$];
    int        j, p, b, k;
    pair_rec_t r;
    spread_x = n_bodies * sq_x - sum_x * sum_x;
    spread_y = n_bodies * sq_y - sum_y * sum_y;
    ya = !(spread_x >= spread_y);
    for (int i = 0; i < n_bodies; i++) begin
      j = i;
      while (j > 0) begin
        p = order[j-1];
        if (axis_min(bodies[p], ya) <= axis_min(bodies[i], ya)) break;
        order[j] = p;
        j--;
      end
      order[j] = i;
    end
    k = 0;
    for (int i = 0; i < n_bodies; i++) begin
      b = order[i];
      if (!bodies[b].en) continue;
      j = 0;
      while (j < active.size()) begin
        if (axis_min(bodies[b], ya) > axis_max(bodies[active[j]], ya)) begin
          active.delete(j);
        end else begin
          r = '{1'b1, b[2:0], active[j][2:0], 1'b0, ya, overflow};
          expected_pairs = {expected_pairs, r};
          k++;
          j++;
        end
      end
      active = {active, b};
    end
    if (k == 0) begin
      r = '{1'b0, 3'd0, 3'd0, 1'b0, ya, overflow};
      expected_pairs = {expected_pairs, r};
    end
    r = expected_pairs[expected_pairs.size() - 1];
    r.last_pair = 1'b1;
    expected_pairs[expected_pairs.size() - 1] = r;
    n_bodies = 0;
    overflow = 0;
    sum_x = 0; sum_y = 0; sq_x = 0; sq_y = 0;
  endtask

  task automatic compare_pair();
    pair_rec_t e;
    if (expected_pairs.size() == 0) begin
      $error("unexpected pair item");
      fail_count++;
      return;
    end
    e = expected_pairs.pop_front();
    if (pairs_out.pair_valid !== e.pair_valid) begin
      $error("pair_valid exp %0d got %0d", e.pair_valid, pairs_out.pair_valid); fail_count++;
    end
    if (pairs_out.newer_body !== e.newer_body) begin
      $error("newer_body exp %0d got %0d", e.newer_body, pairs_out.newer_body); fail_count++;
    end
    if (pairs_out.older_body !== e.older_body) begin
      $error("older_body exp %0d got %0d", e.older_body, pairs_out.older_body); fail_count++;
    end
    if (pairs_out.last_pair !== e.last_pair) begin
      $error("last_pair exp %0d got %0d", e.last_pair, pairs_out.last_pair); fail_count++;
    end
    if (pairs_out.axis_is_y !== e.axis_is_y) begin
      $error("axis_is_y exp %0d got %0d", e.axis_is_y, pairs_out.axis_is_y); fail_count++;
    end
    if (pairs_out.dropped_bodies !== e.dropped_bodies) begin
      $error("dropped_bodies exp %0d got %0d", e.dropped_bodies, pairs_out.dropped_bodies);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    sets_closed = 0;
    pairs_seen = 0;
    n_bodies = 0;
    overflow = 0;
    sum_x = 0; sum_y = 0; sq_x = 0; sq_y = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pairs_out.valid && pairs_out.ready) begin
        compare_pair();
        pairs_seen++;
      end
      if (items_in.valid && items_in.ready) begin
        if (n_bodies < MAX_BODIES) begin
          bodies[n_bodies] = '{items_in.body_enabled, items_in.box_min_x, items_in.box_min_y,
                               items_in.box_max_x, items_in.box_max_y};
          sum_x += longint'(items_in.centre_x);
          sum_y += longint'(items_in.centre_y);
          sq_x += longint'(items_in.centre_x) * longint'(items_in.centre_x);
          sq_y += longint'(items_in.centre_y) * longint'(items_in.centre_y);
          n_bodies++;
        end else begin
          overflow = 1;
        end
        if (items_in.final_body) begin
          sweep_set();
          sets_closed++;
        end
      end
    end
  end

endmodule

// ===== dv/sweep_and_prune_pair_finder_top_tb.sv =====
module sweep_and_prune_pair_finder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spp_pkg::*;

  logic clk;
  logic rst;
  int   fail_count, pending_pairs, sets_closed, pairs_seen;
  int   sent;
  int   stall_mode;

  spp_in_if  items_in ();
  spp_out_if pairs_out ();

  sweep_and_prune_pair_finder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .items_in  (items_in),
    .pairs_out (pairs_out)
  );

  sweep_and_prune_pair_finder_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .items_in      (items_in),
    .pairs_out     (pairs_out),
    .fail_count    (fail_count),
    .pending_pairs (pending_pairs),
    .sets_closed   (sets_closed),
    .pairs_seen    (pairs_seen)
  );

  initial clk = 0;
  always #10 clk = ~clk;

  // receiver stalls on a pattern that changes mode every so often
  int stall_cnt;
  always @(posedge clk) begin
    if (rst) begin
      pairs_out.ready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      case (stall_mode)
        0: pairs_out.ready <= 1'b1;
        1: pairs_out.ready <= (stall_cnt % 4) != 3;
        2: pairs_out.ready <= $urandom_range(0, 2) == 0;
        default: pairs_out.ready <= ($urandom_range(0, 15) < 12);
      endcase
      if (stall_cnt % 97 == 0) stall_mode <= $urandom_range(0, 3);
    end
  end

  function automatic logic signed [15:0] rand_coord(int spread);
    int v;
    case (spread)
      0: v = $urandom_range(0, 65535) - 32768;
      1: v = $urandom_range(0, 400) - 200;
      default: v = $urandom_range(0, 40) - 20;
    endcase
    return v[15:0];
  endfunction

  task automatic send_body(logic signed [15:0] mnx, logic signed [15:0] mny,
                           logic signed [15:0] mxx, logic signed [15:0] mxy,
                           logic signed [15:0] cx, logic signed [15:0] cy,
                           logic en, logic fin);
    items_in.valid        <= 1'b1;
    items_in.box_min_x    <= mnx;
    items_in.box_min_y    <= mny;
    items_in.box_max_x    <= mxx;
    items_in.box_max_y    <= mxy;
    items_in.centre_x     <= cx;
    items_in.centre_y     <= cy;
    items_in.body_enabled <= en;
    items_in.final_body   <= fin;
    @(posedge clk);
    while (!items_in.ready) @(posedge clk);
    sent++;
  endtask

  task automatic idle_gap(int cycles);
    items_in.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic random_body(int spread, logic fin);
    logic signed [15:0] a, b, c, d, cx, cy;
    a = rand_coord(spread);
    b = rand_coord(spread);
    c = a + 16'($urandom_range(0, spread == 0 ? 20000 : 60));
    d = b + 16'($urandom_range(0, spread == 0 ? 20000 : 60));
    if ($urandom_range(0, 19) == 0) c = a - 16'sd5;
    cx = rand_coord(spread);
    cy = rand_coord(spread);
    send_body(a, b, c, d, cx, cy, $urandom_range(0, 5) != 0, fin);
  endtask

  initial begin
    int n, spread, burst;
    rst = 1'b1;
    stall_mode = 0;
    sent = 0;
    items_in.valid        <= 1'b0;
    items_in.box_min_x    <= '0;
    items_in.box_min_y    <= '0;
    items_in.box_max_x    <= '0;
    items_in.box_max_y    <= '0;
    items_in.centre_x     <= '0;
    items_in.centre_y     <= '0;
    items_in.body_enabled <= 1'b0;
    items_in.final_body   <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single body, no pairs
    send_body(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1, 1'b1);
    // touching boxes and equal spreads (all centres equal)
    send_body(16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd5, 16'sd5, 1'b1, 1'b0);
    send_body(16'sd10, 16'sd10, 16'sd20, 16'sd20, 16'sd5, 16'sd5, 1'b1, 1'b0);
    send_body(16'sd21, 16'sd0, 16'sd30, 16'sd5, 16'sd5, 16'sd5, 1'b1, 1'b1);
    // y spread larger, inverted box, disabled body, extremes
    send_body(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sd0, 16'sh8000, 1'b1, 1'b0);
    send_body(16'sd0, 16'sd0, 16'sd5, 16'sd5, 16'sd0, 16'sh7fff, 1'b0, 1'b0);
    send_body(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sd1, 16'sd0, 1'b1, 1'b1);
    // overflow: ten bodies, dropped final body
    for (int i = 0; i < 10; i++)
      send_body(16'(i * 3), 16'(16'sh8000 + i), 16'(i * 3 + 7), 16'sh7fff, 16'(i), 16'sd0,
                1'b1, i == 9);
    idle_gap(3);

    while (sent < 185) begin
      n = $urandom_range(0, 9) == 0 ? $urandom_range(9, 11) : $urandom_range(1, 8);
      spread = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
        random_body(spread, i == n - 1);
        burst = $urandom_range(0, 3);
        if (burst == 0) idle_gap($urandom_range(1, 6));
      end
      if ($urandom_range(0, 1)) idle_gap($urandom_range(1, 30));
    end
    items_in.valid <= 1'b0;

    while (pending_pairs != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("sent %0d bodies in %0d sets, %0d pair items checked", sent, sets_closed,
             pairs_seen);
    if (fail_count == 0 && pending_pairs == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
